/* design/mbe_pkg.sv */
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants of the Mandelbrot escape iterator
// Holds the operand codes, the status and control structs and the register default.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // Width and reset value of the iteration limit register.
  localparam int unsigned IterWidth = 16;
  localparam logic [IterWidth-1:0] MAX_ITER_RESET = 16'd256;

  // Operand selection of the shared multiplier.
  localparam logic [1:0] OPS_RR = 2'd0;  // re * re
  localparam logic [1:0] OPS_II = 2'd1;  // im * im
  localparam logic [1:0] OPS_RI = 2'd2;  // re * im

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic start;     // input transaction accepted this cycle
    logic escape;    // |z|^2 > 4 on the registered squares
    logic out_free;  // output register can take a result this cycle
  } stat_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic [1:0] op_sel;  // multiplier operands
    logic       idle;    // ready for a new point
    logic       load;    // latch c and clear z
    logic       cap_rr;  // capture re^2 from the multiplier
    logic       cap_ii;  // capture im^2 from the multiplier
    logic       upd;     // write z = z^2 + c
    logic       fin;     // load the output register
    logic       zero;    // result is zero (limit reached)
  } ctrl_t;

endpackage

/* design/mandelbrot_escape_iterator.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_iterator: escape-time iteration of z = z^2 + c
// Iterates one complex point in signed fixed point on a shared multiplier and
// returns the final z, or zero when the iteration limit is reached.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake              Payload
// s_axis   in         s_axis_tvalid/tready   c_real, c_imag
// m_axis   out        m_axis_tvalid/tready   z_real, z_imag
// cfg      in         cfg_valid_i/ready_o    max_iterations (16 bits)
//
// Each iteration runs three products on the single shared multiplier (re^2,
// im^2, re*im) and then the escape test and the update of z. The block takes
// one point at a time and is ready again once the result is loaded into the
// output register.
// Reset is asynchronous and active low; it returns the sequencer to idle, the
// output register to empty and the limit to 256. A stalled output holds its
// result, and the next point is accepted once that result is in the output
// register, even if it has not been taken yet.
//
module mandelbrot_escape_iterator #(
  parameter int unsigned FRAC_BITS   = 27,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // c_real in [COORD_WIDTH-1:0], c_imag above it, then zero padding
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // z_real in [COORD_WIDTH-1:0], z_imag above it, then zero padding
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic [mbe_pkg::IterWidth-1:0]          cfg_data_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned TDW  = ((2*W+7)/8)*8;
  localparam int unsigned PW   = 2*W;       // product width
  localparam int unsigned DW   = 2*W + 1;   // difference and doubled product
  localparam int unsigned SW   = 2*W + 2;   // sum before saturation
  localparam int unsigned BEXP = 2*FRAC_BITS + 2;  // exponent of 4.0 squared scale
  localparam int unsigned MW   = (2*W + 1 > BEXP + 1) ? 2*W + 1 : BEXP + 1;

  localparam logic [MW-1:0] BOUND = MW'(1) << BEXP;

  // Saturate a wide signed sum into the coordinate range.
  function automatic logic [W-1:0] sat_fn(input logic [SW-1:0] v);
    logic ovf;
    ovf = (v[SW-1:W-1] != {(SW-W+1){v[SW-1]}});
    return ovf ? {v[SW-1], {(W-1){~v[SW-1]}}} : v[W-1:0];
  endfunction

  mbe_pkg::ctrl_t ctrl;
  mbe_pkg::stat_t stat;

  logic [mbe_pkg::IterWidth-1:0] max_iter_q;

  logic signed [W-1:0]  c_re_q, c_im_q, z_re_q, z_im_q;
  logic signed [PW-1:0] rr_q, ii_q;
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;

  logic [MW-1:0]        mag;
  logic signed [DW-1:0] diff, ri2, diff_sh, ri2_sh;
  logic [SW-1:0]        sum_re, sum_im;
  logic [W-1:0]         z_re_new, z_im_new;

  logic [TDW-1:0] out_data_q;
  logic           out_valid_q;

  // --------------------------------------------------------------------------
  // Configuration register. Writes are only expected while idle.
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= mbe_pkg::MAX_ITER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_iter_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier and its operand selection.
  // --------------------------------------------------------------------------
  always_comb begin
    case (ctrl.op_sel)
      mbe_pkg::OPS_RR: begin
        mul_a = z_re_q;
        mul_b = z_re_q;
      end
      mbe_pkg::OPS_II: begin
        mul_a = z_im_q;
        mul_b = z_im_q;
      end
      mbe_pkg::OPS_RI: begin
        mul_a = z_re_q;
        mul_b = z_im_q;
      end
      default: begin
        mul_a = z_re_q;
        mul_b = z_re_q;
      end
    endcase
  end

  mbe_mul #(
    .W (W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // --------------------------------------------------------------------------
  // Escape test and update. Both squares are non-negative, so their sum is
  // compared unsigned. In the test cycle the multiplier output holds re*im.
  // --------------------------------------------------------------------------
  assign mag = MW'(rr_q[PW-1:0]) + MW'(ii_q[PW-1:0]);

  assign diff    = {rr_q[PW-1], rr_q} - {ii_q[PW-1], ii_q};
  assign ri2     = {prod, 1'b0};
  assign diff_sh = diff >>> FRAC_BITS;
  assign ri2_sh  = ri2 >>> FRAC_BITS;

  assign sum_re = {{(SW-DW){diff_sh[DW-1]}}, diff_sh} + {{(SW-W){c_re_q[W-1]}}, c_re_q};
  assign sum_im = {{(SW-DW){ri2_sh[DW-1]}}, ri2_sh} + {{(SW-W){c_im_q[W-1]}}, c_im_q};

  assign z_re_new = sat_fn(sum_re);
  assign z_im_new = sat_fn(sum_im);

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      c_re_q <= s_axis_tdata[W-1:0];
      c_im_q <= s_axis_tdata[2*W-1:W];
      z_re_q <= '0;
      z_im_q <= '0;
    end else if (ctrl.upd) begin
      z_re_q <= z_re_new;
      z_im_q <= z_im_new;
    end
    if (ctrl.cap_rr) begin
      rr_q <= prod;
    end
    if (ctrl.cap_ii) begin
      ii_q <= prod;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  assign stat.start    = s_axis_tvalid && s_axis_tready;
  assign stat.escape   = (mag > BOUND);
  assign stat.out_free = !out_valid_q || m_axis_tready;

  mbe_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_iter_i (max_iter_q),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  assign s_axis_tready = ctrl.idle;

  // --------------------------------------------------------------------------
  // Output register. It decouples the result from the next point.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.fin) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fin) begin
      out_data_q <= ctrl.zero ? '0 : TDW'({z_im_q, z_re_q});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // A point is being iterated right after it is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still ready right after a transaction");

  // The block becomes ready again only by delivering a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> $past(ctrl.fin))
    else $error("ready returned without a result");

  // A finished point shows up at the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.fin |=> m_axis_tvalid)
    else $error("result not presented after finishing");

  // A point that reached the limit yields zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.fin && ctrl.zero) |=> (m_axis_tdata == '0))
    else $error("limit reached but result is not zero");

endmodule

/* design/mbe_mul.sv */
// ----------------------------------------------------------------------------
// mbe_mul: shared signed multiplier with a registered product
// One W x W signed product per cycle, registered and available in the cycle after its operands.
// ----------------------------------------------------------------------------
module mbe_mul #(
  parameter int unsigned W = 32
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  logic signed [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

/* design/mbe_seq.sv */
// ----------------------------------------------------------------------------
// mbe_seq: iteration sequencer of the Mandelbrot escape iterator
// Steps the shared multiplier through re^2, im^2 and re*im, counts iterations
// and decides between escape and reaching the limit.
// ----------------------------------------------------------------------------
module mbe_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mbe_pkg::IterWidth-1:0]  max_iter_i,
  input  mbe_pkg::stat_t                 stat_i,
  output mbe_pkg::ctrl_t                 ctrl_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RR   = 3'd1;
  localparam logic [2:0] ST_II   = 3'd2;
  localparam logic [2:0] ST_RI   = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]                      state_q, state_d;
  logic [mbe_pkg::IterWidth-1:0]   cnt_q, cnt_d;
  logic                            zero_q, zero_d;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    zero_d         = zero_q;
    ctrl_o         = '0;
    ctrl_o.op_sel  = mbe_pkg::OPS_RR;
    ctrl_o.zero    = zero_q;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.idle = 1'b1;
        if (stat_i.start) begin
          ctrl_o.load = 1'b1;
          cnt_d       = '0;
          state_d     = ST_RR;
        end
      end
      ST_RR: begin
        ctrl_o.op_sel = mbe_pkg::OPS_RR;
        if (cnt_q == max_iter_i) begin
          zero_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_II;
        end
      end
      ST_II: begin
        ctrl_o.op_sel = mbe_pkg::OPS_II;
        ctrl_o.cap_rr = 1'b1;
        state_d       = ST_RI;
      end
      ST_RI: begin
        ctrl_o.op_sel = mbe_pkg::OPS_RI;
        ctrl_o.cap_ii = 1'b1;
        state_d       = ST_CHK;
      end
      ST_CHK: begin
        if (stat_i.escape) begin
          zero_d  = 1'b0;
          state_d = ST_DONE;
        end else begin
          ctrl_o.upd = 1'b1;
          cnt_d      = cnt_q + 1'b1;
          state_d    = ST_RR;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.fin = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      zero_q  <= zero_d;
    end
  end

  // The counter never passes the limit while a point is iterated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK) |-> (cnt_q < max_iter_i))
    else $error("iteration count reached the limit before the escape test");

  // Reaching the limit always produces a zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RR && cnt_q == max_iter_i) |=> (state_q == ST_DONE && zero_q))
    else $error("limit reached without a zero result");

  // An update always counts one more iteration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.upd |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("update without an iteration count step");

endmodule
